### design/sbrm_pkg.sv
// Shared types, codes and constants of the skip-branch register machine.
`timescale 1ns / 1ps
package sbrm_pkg;

	localparam int DW = 32;
	localparam int NUM_SLOTS_DEF = 3;
	localparam int NUM_REGS_DEF = 3;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_EXEC  = 2'd1,
		REQ_READ  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MOD = 3'd4,
		OP_SKN = 3'd5,
		OP_SKP = 3'd6,
		OP_SKZ = 3'd7
	} op_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [1:0]         slot_index;
		logic signed [31:0] load_value;
		logic [2:0]         opcode;
		logic               dest_kind;
		logic [1:0]         dest_index;
		logic [1:0]         src_kind;
		logic [1:0]         src_index;
		logic signed [31:0] src_literal;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               skipped;
		logic               branch_taken;
		logic               div_error;
	} rsp_t;

	// Classified request as it sits in the queue between front and back.
	typedef struct packed {
		req_kind_t     kind;
		op_t           op;
		logic          dst_reg;
		logic [1:0]    dst_idx;
		logic          dst_ok;
		logic          src_reg;
		logic [1:0]    src_idx;
		logic          src_ok;
		logic          src_lit;
		logic [DW-1:0] imm;
	} cmd_t;

	typedef struct packed {
		logic          start;
		logic          is_mod;
		logic [DW-1:0] dividend;
		logic [DW-1:0] divisor;
	} div_req_t;

endpackage

### design/skip_branch_register_machine_exec_unit.sv
// Top level of the skip-branch register machine execution unit.
`timescale 1ns / 1ps
// Executes one request per transaction on a machine of NUM_SLOTS input slots and
// NUM_REGS scratch registers, 32 bits each, and returns exactly one response
// transaction per request, in order. A request loads a slot, reads a slot, clears
// all state, or executes one instruction: add, sub or mul (wrapping at 32 bits),
// div or mod (truncating; division by zero and the minimum value over -1 leave the
// destination as it was and set div_error), or a branch that, when its test on the
// destination holds, skips the next N executed instructions, or all of them until
// reset or clear when N is negative. Loads and reads are never skipped. The front
// end registers and classifies each request and hands it to a two-entry queue, so
// new requests keep arriving while the back end works or a response is stalled.
// The back end reads the register file in its fetch state and executes in its
// execute state; div and mod then wait in a divide state for the shared divider,
// which produces one quotient bit per cycle plus a sign fix-up. Requests are
// executed one at a time because each instruction may depend on the result and
// skip count left by the one before it. A request passes the front register, the
// queue, the fetch and the execute state before it reaches the response register,
// and the response is held until it is taken.
module skip_branch_register_machine_exec_unit #(
	parameter int NUM_SLOTS = sbrm_pkg::NUM_SLOTS_DEF,
	parameter int NUM_REGS  = sbrm_pkg::NUM_REGS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sbrm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sbrm_pkg::rsp_t rsp
);
	import sbrm_pkg::*;

	cmd_t push_data;
	cmd_t q_head;
	logic push;
	logic q_full;
	logic q_pop;
	logic q_empty;

	sbrm_front #(
		.NUM_SLOTS (NUM_SLOTS),
		.NUM_REGS  (NUM_REGS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_data (push_data),
		.full      (q_full)
	);

	sbrm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// The back end only pops a command it has finished, so the queue head stays
	// put while a division is in progress.
	sbrm_back #(
		.NUM_SLOTS (NUM_SLOTS),
		.NUM_REGS  (NUM_REGS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### design/sbrm_front.sv
// Front end: accepts requests and classifies them into queue commands.
`timescale 1ns / 1ps
module sbrm_front #(
	parameter int NUM_SLOTS = sbrm_pkg::NUM_SLOTS_DEF,
	parameter int NUM_REGS  = sbrm_pkg::NUM_REGS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sbrm_pkg::req_t req,
	output logic           push,
	output sbrm_pkg::cmd_t push_data,
	input  logic           full
);
	import sbrm_pkg::*;

	cmd_t cmd_d;
	cmd_t cmd_s1;
	logic valid_s1;

	function automatic logic in_range(logic is_reg, logic [1:0] idx);
		if (is_reg) begin
			return int'(idx) < NUM_REGS;
		end
		return int'(idx) < NUM_SLOTS;
	endfunction

	always_comb begin
		cmd_d         = '0;
		cmd_d.kind    = req_kind_t'(req.req_type);
		cmd_d.op      = op_t'(req.opcode);
		cmd_d.src_lit = req.src_kind[1];
		cmd_d.src_reg = req.src_kind[0];
		cmd_d.src_idx = req.src_index;
		cmd_d.src_ok  = !req.src_kind[1] && in_range(req.src_kind[0], req.src_index);
		if (cmd_d.kind == REQ_EXEC) begin
			cmd_d.dst_reg = req.dest_kind;
			cmd_d.dst_idx = req.dest_index;
			cmd_d.imm     = req.src_literal;
		end else begin
			cmd_d.dst_reg = 1'b0;
			cmd_d.dst_idx = req.slot_index;
			cmd_d.imm     = req.load_value;
		end
		cmd_d.dst_ok = in_range(cmd_d.dst_reg, cmd_d.dst_idx);
	end

	assign push      = valid_s1 && !full;
	assign req_stall = valid_s1 && full;
	assign push_data = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

### design/sbrm_queue.sv
// Short command queue that decouples the front end from the execution back end.
`timescale 1ns / 1ps
module sbrm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sbrm_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output sbrm_pkg::cmd_t head,
	output logic           empty
);
	import sbrm_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(logic [PW-1:0] ptr);
		if (ptr == PW'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + 1'b1;
	endfunction

	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### design/sbrm_div.sv
// Shift-subtract signed divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sbrm_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sbrm_pkg::div_req_t      req,
	output logic                    busy,
	output logic [sbrm_pkg::DW-1:0] result
);
	import sbrm_pkg::*;

	localparam int CW = $clog2(DW);

	typedef enum logic [2:0] {
		DV_IDLE = 3'b001,
		DV_STEP = 3'b010,
		DV_FIX  = 3'b100
	} dv_state_t;

	dv_state_t     state_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvsr_q;
	logic [DW-1:0] result_q;
	logic          neg_quo_q;
	logic          neg_rem_q;
	logic          is_mod_q;
	logic [DW:0]   trial;

	function automatic logic [DW-1:0] magnitude(logic [DW-1:0] v);
		return v[DW-1] ? (~v + 1'b1) : v;
	endfunction

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial  = {rem_q, quo_q[DW-1]} - {1'b0, dvsr_q};
	assign busy   = (state_q != DV_IDLE);
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				DV_IDLE: begin
					if (req.start) begin
						state_q <= DV_STEP;
						cnt_q   <= '0;
					end
				end
				DV_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DW - 1)) begin
						state_q <= DV_FIX;
					end
				end
				DV_FIX: begin
					state_q <= DV_IDLE;
				end
				default: begin
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && req.start) begin
			quo_q     <= magnitude(req.dividend);
			dvsr_q    <= magnitude(req.divisor);
			rem_q     <= '0;
			neg_quo_q <= req.dividend[DW-1] ^ req.divisor[DW-1];
			neg_rem_q <= req.dividend[DW-1];
			is_mod_q  <= req.is_mod;
		end else if (state_q == DV_STEP) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end else if (state_q == DV_FIX) begin
			if (is_mod_q) begin
				result_q <= neg_rem_q ? (~rem_q + 1'b1) : rem_q;
			end else begin
				result_q <= neg_quo_q ? (~quo_q + 1'b1) : quo_q;
			end
		end
	end

endmodule

### design/sbrm_back.sv
// Back end: register file, skip state, arithmetic and the response register.
`timescale 1ns / 1ps
module sbrm_back #(
	parameter int NUM_SLOTS = sbrm_pkg::NUM_SLOTS_DEF,
	parameter int NUM_REGS  = sbrm_pkg::NUM_REGS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  sbrm_pkg::cmd_t q_head,
	output logic           q_pop,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sbrm_pkg::rsp_t rsp
);
	import sbrm_pkg::*;

	localparam int DEPTH = NUM_SLOTS + NUM_REGS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {
		BK_FETCH = 3'b001,
		BK_EXEC  = 3'b010,
		BK_DIV   = 3'b100
	} bk_state_t;

	bk_state_t      state_q;
	bk_state_t      state_d;

	// Slots live at the low addresses, scratch registers above them.
	logic [DW-1:0]    file_mem [DEPTH];
	logic [DEPTH-1:0] file_vld_q;
	logic [DW-1:0]    rd_a_q;
	logic [DW-1:0]    rd_b_q;
	logic             rd_va_q;
	logic             rd_vb_q;

	logic [AW-1:0]  dst_addr;
	logic [AW-1:0]  src_addr;
	logic [DW-1:0]  opnd_a;
	logic [DW-1:0]  opnd_b;
	logic [DW-1:0]  arith;
	logic           div_fault;
	logic           skipping;
	logic           cond;
	logic           out_free;

	logic           wr_en;
	logic [DW-1:0]  wr_data;
	logic           clr;
	logic           out_load;
	rsp_t           out_d;
	rsp_t           out_q;
	logic           out_valid_q;
	logic [DW-1:0]  skip_left_q;
	logic [DW-1:0]  skip_left_d;
	logic           skip_rest_q;
	logic           skip_rest_d;

	div_req_t       div_req;
	logic           div_busy;
	logic [DW-1:0]  div_result;

	function automatic logic [AW-1:0] file_addr(logic is_reg, logic [1:0] idx);
		if (is_reg) begin
			return AW'(NUM_SLOTS) + AW'(idx);
		end
		return AW'(idx);
	endfunction

	assign dst_addr = file_addr(q_head.dst_reg, q_head.dst_idx);
	assign src_addr = file_addr(q_head.src_reg, q_head.src_idx);

	// Entries never written since reset or clear read as zero.
	assign opnd_a = rd_va_q ? rd_a_q : '0;
	assign opnd_b = q_head.src_lit ? q_head.imm : (rd_vb_q ? rd_b_q : '0);

	assign skipping  = skip_rest_q || (skip_left_q != '0);
	assign div_fault = (opnd_b == '0) ||
		(opnd_a == {1'b1, {(DW-1){1'b0}}} && opnd_b == {DW{1'b1}});
	assign out_free  = !out_valid_q || !rsp_stall;

	always_comb begin
		case (q_head.op)
			OP_ADD:  arith = opnd_a + opnd_b;
			OP_SUB:  arith = opnd_a - opnd_b;
			OP_MUL:  arith = DW'(opnd_a * opnd_b);
			default: arith = opnd_a;
		endcase
	end

	always_comb begin
		case (q_head.op)
			OP_SKN:  cond = opnd_a[DW-1];
			OP_SKP:  cond = (opnd_a != '0) && !opnd_a[DW-1];
			OP_SKZ:  cond = (opnd_a == '0);
			default: cond = 1'b0;
		endcase
	end

	always_comb begin
		state_d        = state_q;
		q_pop          = 1'b0;
		wr_en          = 1'b0;
		wr_data        = arith;
		clr            = 1'b0;
		out_load       = 1'b0;
		out_d          = '0;
		skip_left_d    = skip_left_q;
		skip_rest_d    = skip_rest_q;
		div_req        = '0;
		div_req.is_mod = (q_head.op == OP_MOD);
		div_req.dividend = opnd_a;
		div_req.divisor  = opnd_b;
		unique case (state_q)
			BK_FETCH: begin
				if (!q_empty) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (out_free) begin
					out_load = 1'b1;
					q_pop    = 1'b1;
					state_d  = BK_FETCH;
					unique case (q_head.kind)
						REQ_LOAD: begin
							wr_en   = q_head.dst_ok;
							wr_data = q_head.imm;
							out_d.result_value = q_head.dst_ok ? q_head.imm : '0;
						end
						REQ_READ: begin
							out_d.result_value = opnd_a;
						end
						REQ_CLEAR: begin
							clr         = 1'b1;
							skip_left_d = '0;
							skip_rest_d = 1'b0;
						end
						REQ_EXEC: begin
							if (skipping) begin
								out_d.skipped      = 1'b1;
								out_d.result_value = opnd_a;
								if (!skip_rest_q) begin
									skip_left_d = skip_left_q - 1'b1;
								end
							end else begin
								unique case (q_head.op) inside
									OP_SKN, OP_SKP, OP_SKZ: begin
										out_d.result_value = opnd_a;
										if (cond && opnd_b != '0) begin
											out_d.branch_taken = 1'b1;
											if (opnd_b[DW-1]) begin
												skip_rest_d = 1'b1;
											end else begin
												skip_left_d = opnd_b;
											end
										end
									end
									OP_DIV, OP_MOD: begin
										if (div_fault) begin
											out_d.div_error    = 1'b1;
											out_d.result_value = opnd_a;
										end else begin
											out_load      = 1'b0;
											q_pop         = 1'b0;
											div_req.start = 1'b1;
											state_d       = BK_DIV;
										end
									end
									OP_ADD, OP_SUB, OP_MUL: begin
										wr_en = q_head.dst_ok;
										out_d.result_value = q_head.dst_ok ? arith : '0;
									end
								endcase
							end
						end
					endcase
				end
			end
			BK_DIV: begin
				if (!div_busy && out_free) begin
					out_load = 1'b1;
					q_pop    = 1'b1;
					wr_en    = q_head.dst_ok;
					wr_data  = div_result;
					out_d.result_value = q_head.dst_ok ? div_result : '0;
					state_d  = BK_FETCH;
				end
			end
			default: begin
				state_d = BK_FETCH;
			end
		endcase
	end

	sbrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.result (div_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_FETCH;
			skip_left_q <= '0;
			skip_rest_q <= 1'b0;
			file_vld_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			skip_left_q <= skip_left_d;
			skip_rest_q <= skip_rest_d;
			if (clr) begin
				file_vld_q <= '0;
			end else if (wr_en) begin
				file_vld_q[dst_addr] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			file_mem[dst_addr] <= wr_data;
		end
		if (state_q == BK_FETCH && !q_empty) begin
			rd_a_q  <= file_mem[dst_addr];
			rd_b_q  <= file_mem[src_addr];
			rd_va_q <= file_vld_q[dst_addr] && q_head.dst_ok;
			rd_vb_q <= file_vld_q[src_addr] && q_head.src_ok;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

### design/sbrm_checker.sv
// Port-level checks of the execution unit and their attachment to the top level.
`timescale 1ns / 1ps
module sbrm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input sbrm_pkg::rsp_t rsp
);

	// The response valid flag is cleared asynchronously by reset, so the check
	// looks at the next sample.
	a_no_rsp_in_reset: assert property (@(posedge clk) !arst_n |=> !rsp_valid)
		else $error("Response valid while reset is asserted.");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled response changed or was dropped.");

	a_skip_not_taken: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.skipped && rsp.branch_taken))
		else $error("A skipped instruction reported a taken branch.");

	a_div_error_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.div_error |-> !rsp.skipped && !rsp.branch_taken)
		else $error("Division error reported on a skipped instruction or branch.");

endmodule

bind skip_branch_register_machine_exec_unit sbrm_checker u_sbrm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
